// File: src/rotary_encoder_interface_macros.svh
// Assertion helpers for the rotary encoder interface.
// Both sample on the rising edge of clk and are off while arst_n is low.
`ifndef ROTARY_ENCODER_INTERFACE_MACROS_SVH
`define ROTARY_ENCODER_INTERFACE_MACROS_SVH

// Property that must hold in the same cycle.
`define REI_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define REI_ASSERT_NEXT(name, trig, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

// File: src/rei_pkg.sv
`default_nettype none

package rei_pkg;

	localparam int COUNT_WIDTH = 8;
	localparam int TICK_WIDTH  = 8;

	localparam logic [TICK_WIDTH-1:0] DEBOUNCE_RESET = TICK_WIDTH'(20);

	typedef enum logic [1:0] {
		REQ_PIN    = 2'd0,
		REQ_TICK   = 2'd1,
		REQ_STEPS  = 2'd2,
		REQ_BUTTON = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		EVT_NONE     = 2'd0,
		EVT_PRESSED  = 2'd1,
		EVT_RELEASED = 2'd2
	} btn_evt_t;

	localparam logic [5:0] DIR_MASK   = 6'h30;
	localparam logic [5:0] DIR_CW     = 6'h10;
	localparam logic [5:0] DIR_CCW    = 6'h20;
	localparam logic [5:0] STATE_MASK = 6'h0f;

	// next state / direction, indexed by [state][{phase_b, phase_a}]
	localparam logic [5:0] STEP_TABLE [8][4] = '{
		'{6'h00, 6'h02, 6'h04, 6'h00},
		'{6'h03, 6'h00, 6'h01, 6'h10},
		'{6'h03, 6'h02, 6'h00, 6'h00},
		'{6'h03, 6'h02, 6'h01, 6'h00},
		'{6'h06, 6'h00, 6'h04, 6'h00},
		'{6'h06, 6'h05, 6'h00, 6'h20},
		'{6'h06, 6'h05, 6'h04, 6'h00},
		'{6'h00, 6'h02, 6'h04, 6'h00}
	};

	typedef struct packed {
		req_t req;
		logic phase_a;
		logic phase_b;
		logic button_level;
	} rei_item_t;

	typedef struct packed {
		logic      fire;
		rei_item_t item;
	} rei_ctl_t;

endpackage

`default_nettype wire

// File: src/rei_quad.sv
`default_nettype none

module rei_quad import rei_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire rei_ctl_t               ctl,
	output logic     [COUNT_WIDTH-1:0]  count
);

	logic [2:0]             state_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic [5:0]             nxt;
	logic [5:0]             dir;

	assign nxt   = STEP_TABLE[state_q][{ctl.item.phase_b, ctl.item.phase_a}];
	assign dir   = nxt & DIR_MASK;
	assign count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			count_q <= '0;
		end else if (ctl.fire) begin
			case (ctl.item.req)
				REQ_PIN: begin
					state_q <= 3'(nxt & STATE_MASK);
					if (dir == DIR_CW) begin
						count_q <= count_q + COUNT_WIDTH'(1);
					end else if (dir == DIR_CCW) begin
						count_q <= count_q - COUNT_WIDTH'(1);
					end
				end
				REQ_STEPS: count_q <= '0;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: src/rei_button.sv
`default_nettype none

module rei_button import rei_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [TICK_WIDTH-1:0] cfg_wdata,
	input  wire rei_ctl_t              ctl,
	output btn_evt_t                   event_code
);

	logic [TICK_WIDTH-1:0] ticks_q;
	logic [TICK_WIDTH-1:0] cnt_q;
	logic [TICK_WIDTH-1:0] cnt_inc;
	logic                  stable_q;
	logic                  pressed;
	btn_evt_t              evt_q;

	assign pressed    = ~ctl.item.button_level;
	assign cnt_inc    = cnt_q + TICK_WIDTH'(1);
	assign event_code = evt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= DEBOUNCE_RESET;
		end else if (cfg_we) begin
			ticks_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			stable_q <= 1'b0;
			evt_q    <= EVT_NONE;
		end else if (ctl.fire) begin
			case (ctl.item.req)
				REQ_TICK: begin
					if (pressed != stable_q) begin
						if (cnt_inc == ticks_q) begin
							cnt_q    <= '0;
							stable_q <= pressed;
							evt_q    <= pressed ? EVT_PRESSED : EVT_RELEASED;
						end else begin
							cnt_q <= cnt_inc;
						end
					end else begin
						cnt_q <= '0;
					end
				end
				REQ_BUTTON: evt_q <= EVT_NONE;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: src/rotary_encoder_interface.sv
// Rotary encoder interface: quadrature detent counter plus debounced button.
// Input channel (in_valid/in_ready) carries one request word: req_type with
// phase_a/phase_b for a pin change, button_level for a debounce tick, or a
// read of the step count or the latched button event.
// Output channel (out_valid/out_ready) returns one word per read request:
// steps_read for a step read, button_read for a button read, the other 0.
// Pin changes and ticks give no output word.
// A word lands in the input register on acceptance; a read's result is then
// loaded into the output register, raising out_valid, once that register is free.
// Throughput: one request per cycle unless a read stalls; the input and output
// register each hold one word, so a new request is taken while a result waits.
// When the receiver stalls, a read waiting in the input register holds until
// the output register frees; pin changes and ticks keep flowing meanwhile
// only up to that read, since order is kept.
// cfg_we/cfg_wdata write debounce_ticks; users write only while idle (unchecked).
// Reset clears the decoder to its start state, the count, the button state
// and event, and sets debounce_ticks to 20.
`default_nettype none
`include "rotary_encoder_interface_macros.svh"

module rotary_encoder_interface import rei_pkg::*; (
	input  wire  logic                  clk,
	input  wire  logic                  arst_n,
	input  wire  logic                  cfg_we,
	input  wire  logic [TICK_WIDTH-1:0] cfg_wdata,
	input  wire  logic                  in_valid,
	output logic                        in_ready,
	input  wire  logic [1:0]            req_type,
	input  wire  logic                  phase_a,
	input  wire  logic                  phase_b,
	input  wire  logic                  button_level,
	output logic                        out_valid,
	input  wire  logic                  out_ready,
	output logic signed [7:0]           steps_read,
	output logic       [1:0]            button_read
);

	logic                   valid_s1;
	rei_item_t              item_s1;
	logic                   has_res;
	logic                   out_free;
	logic                   fire_s1;
	rei_ctl_t               ctl;
	logic [COUNT_WIDTH-1:0] count;
	btn_evt_t               event_code;
	logic                   out_valid_q;
	logic [7:0]             steps_q;
	logic [1:0]             button_q;

	assign has_res  = (item_s1.req == REQ_STEPS) || (item_s1.req == REQ_BUTTON);
	assign out_free = !out_valid_q || out_ready;
	assign fire_s1  = valid_s1 && (!has_res || out_free);
	assign in_ready = !valid_s1 || fire_s1;

	assign ctl.fire = fire_s1;
	assign ctl.item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.req          <= req_t'(req_type);
			item_s1.phase_a      <= phase_a;
			item_s1.phase_b      <= phase_b;
			item_s1.button_level <= button_level;
		end
	end

	rei_quad u_quad (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.count  (count)
	);

	rei_button u_button (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.ctl        (ctl),
		.event_code (event_code)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && has_res) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && has_res) begin
			if (item_s1.req == REQ_STEPS) begin
				steps_q  <= 8'(count);
				button_q <= EVT_NONE;
			end else begin
				steps_q  <= '0;
				button_q <= event_code;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign steps_read  = signed'(steps_q);
	assign button_read = button_q;

	`REI_ASSERT_NEXT(a_res_load, fire_s1 && has_res, out_valid_q, "read result not loaded")
	`REI_ASSERT(a_no_clobber, !(valid_s1 && has_res && out_valid_q && !out_ready) || !fire_s1,
		"result register overwritten while stalled")
	`REI_ASSERT(a_one_field, !out_valid_q || steps_q == 8'd0 || button_q == 2'd0,
		"both result fields set")
	`REI_ASSERT(a_evt_code, !out_valid_q || button_q != 2'd3, "illegal button event code")

endmodule

`default_nettype wire
